// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sampler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define HBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hbs_pkg.sv =====
// ---------------------------------------------------------------------------
// hbs_pkg
// Types and constants shared by the heightmap bilinear sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

  localparam int MAP_SIZE      = 1024;
  localparam int MAP_BITS      = $clog2(MAP_SIZE);
  localparam int MAP_AW        = 2 * MAP_BITS;
  localparam int MAP_DEPTH     = MAP_SIZE * MAP_SIZE;
  localparam int POS_W         = 18;
  localparam int POS_FRAC_BITS = 8;
  localparam int POS_INT_W     = POS_W - POS_FRAC_BITS;
  localparam int HEIGHT_W      = 8;
  localparam int SHIFT_W       = 3;
  localparam int MAX_SHIFT     = (1 << SHIFT_W) - 1;
  localparam int FRAC_W        = POS_FRAC_BITS + MAX_SHIFT;
  localparam int WGT_W         = FRAC_W + 1;
  localparam int FSH_W         = $clog2(FRAC_W + 1);
  localparam int S2_W          = FSH_W + 1;
  localparam int NXT_W         = MAP_BITS + (1 << SHIFT_W);
  localparam int PROD_W        = HEIGHT_W + WGT_W;
  localparam int SUM_W         = PROD_W + WGT_W;
  localparam int WIDE_W        = SUM_W + 8;
  localparam int GH_W          = 16;
  localparam int FIFO_DEPTH    = 4;   // power of two
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

  localparam logic [SHIFT_W-1:0] CELL_SHIFT_RST = SHIFT_W'(4);

  typedef logic [MAP_BITS-1:0]  map_idx_t;
  typedef logic [MAP_AW-1:0]    map_addr_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [POS_INT_W-1:0] pint_t;
  typedef logic [HEIGHT_W-1:0]  height_t;
  typedef logic [SHIFT_W-1:0]   shift_t;
  typedef logic [FRAC_W-1:0]    frac_t;
  typedef logic [WGT_W-1:0]     wgt_t;
  typedef logic [FSH_W-1:0]     fsh_t;
  typedef logic [S2_W-1:0]      s2_t;
  typedef logic [NXT_W-1:0]     nxt_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [WIDE_W-1:0]    wide_t;
  typedef logic [GH_W-1:0]      gh_t;
  typedef logic [FIFO_PTR_W-1:0] qptr_t;
  typedef logic [FIFO_PTR_W:0]   qcnt_t;

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  // Corner being read; order of issue is C00, C01, C10, C11.
  typedef enum logic [1:0] {
    CRN_00 = 2'd0,
    CRN_01 = 2'd1,
    CRN_10 = 2'd2,
    CRN_11 = 2'd3
  } corner_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_C01  = 2'd1,
    SEQ_C10  = 2'd2,
    SEQ_C11  = 2'd3
  } seq_e;

  // Classified command as held in the queue.
  typedef struct packed {
    func_e     func;
    map_addr_t waddr;
    height_t   wdata;
    map_idx_t  col0;
    map_idx_t  col1;
    map_idx_t  row0;
    map_idx_t  row1;
    frac_t     fx;
    frac_t     fz;
    wgt_t      wx;
    wgt_t      wz;
    shift_t    cs;
  } cmd_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } qhead_t;

endpackage

`default_nettype wire

// ===== rtl/core/hbs_ram.sv =====
// ---------------------------------------------------------------------------
// hbs_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/hbs_front.sv =====
// ---------------------------------------------------------------------------
// hbs_front
// Accepts command beats and turns a query into corner indices and weights.
// ---------------------------------------------------------------------------
`default_nettype none

module hbs_front (
  input  logic                  start_i,
  input  logic                  full_i,
  input  logic                  func_i,
  input  hbs_pkg::map_addr_t    map_addr_i,
  input  hbs_pkg::height_t      map_value_i,
  input  hbs_pkg::pos_t         pos_x_i,
  input  hbs_pkg::pos_t         pos_z_i,
  input  hbs_pkg::shift_t       cell_shift_i,
  output logic                  busy_o,
  output logic                  push_o,
  output hbs_pkg::cmd_t         cmd_o
);

  typedef struct packed {
    hbs_pkg::map_idx_t base;
    hbs_pkg::map_idx_t next;
    hbs_pkg::frac_t    frac;
    hbs_pkg::wgt_t     wgt;
  } axis_t;

  // Split one coordinate: cell base position, neighbour, fraction, 1-fraction.
  function automatic axis_t split_axis(input hbs_pkg::pos_t pos,
                                       input hbs_pkg::shift_t cs);
    hbs_pkg::fsh_t  s;
    hbs_pkg::pint_t ipart;
    hbs_pkg::nxt_t  nxt;
    hbs_pkg::frac_t mask;
    axis_t          r;
    s     = hbs_pkg::fsh_t'(hbs_pkg::POS_FRAC_BITS) + hbs_pkg::fsh_t'(cs);
    // (pos >> S) << cs is the integer part with its low cs bits cleared
    ipart = pos[hbs_pkg::POS_W-1:hbs_pkg::POS_FRAC_BITS]
          & ~((hbs_pkg::pint_t'(1) << cs) - hbs_pkg::pint_t'(1));
    r.base = hbs_pkg::map_idx_t'(ipart);
    nxt    = hbs_pkg::nxt_t'(r.base) + (hbs_pkg::nxt_t'(1) << cs);
    r.next = (nxt >= hbs_pkg::nxt_t'(hbs_pkg::MAP_SIZE)) ? '0 : hbs_pkg::map_idx_t'(nxt);
    mask   = ~({hbs_pkg::FRAC_W{1'b1}} << s);
    r.frac = pos[hbs_pkg::FRAC_W-1:0] & mask;
    r.wgt  = (hbs_pkg::wgt_t'(1) << s) - hbs_pkg::wgt_t'(r.frac);
    return r;
  endfunction

  axis_t ax_x;
  axis_t ax_z;

  assign busy_o = full_i;
  assign push_o = start_i & ~full_i;

  always_comb begin
    ax_x = split_axis(pos_x_i, cell_shift_i);
    ax_z = split_axis(pos_z_i, cell_shift_i);
    cmd_o.func  = hbs_pkg::func_e'(func_i);
    cmd_o.waddr = map_addr_i;   // 20-bit address always lies inside the map
    cmd_o.wdata = map_value_i;
    cmd_o.col0  = ax_x.base;
    cmd_o.col1  = ax_x.next;
    cmd_o.row0  = ax_z.base;
    cmd_o.row1  = ax_z.next;
    cmd_o.fx    = ax_x.frac;
    cmd_o.fz    = ax_z.frac;
    cmd_o.wx    = ax_x.wgt;
    cmd_o.wz    = ax_z.wgt;
    cmd_o.cs    = cell_shift_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hbs_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// hbs_cmd_fifo
// Short command queue between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module hbs_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hbs_pkg::cmd_t   cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output hbs_pkg::qhead_t head_o
);

  hbs_pkg::cmd_t  fifo_q [hbs_pkg::FIFO_DEPTH];
  hbs_pkg::qptr_t wptr_q, wptr_d;
  hbs_pkg::qptr_t rptr_q, rptr_d;
  hbs_pkg::qcnt_t cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? wptr_q + hbs_pkg::qptr_t'(1) : wptr_q;
    rptr_d = pop_i  ? rptr_q + hbs_pkg::qptr_t'(1) : rptr_q;
    cnt_d  = cnt_q + hbs_pkg::qcnt_t'(push_i) - hbs_pkg::qcnt_t'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wptr_q] <= cmd_i;
    end
  end

  assign full_o     = (cnt_q == hbs_pkg::qcnt_t'(hbs_pkg::FIFO_DEPTH));
  assign head_o.vld = (cnt_q != '0);
  assign head_o.cmd = fifo_q[rptr_q];

endmodule

`default_nettype wire

// ===== rtl/core/hbs_back.sv =====
// ---------------------------------------------------------------------------
// hbs_back
// Owns the height memory: applies writes, reads four corners per query
// and blends them through a short multiply pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module hbs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hbs_pkg::qhead_t head_i,
  output logic            pop_o,
  output logic            result_valid_o,
  output hbs_pkg::gh_t    ground_height_o
);

  hbs_pkg::seq_e      state_q, state_d;
  hbs_pkg::cmd_t      cur_q;
  logic               load;
  logic               ram_we;
  logic               rd_en;
  hbs_pkg::corner_e   rd_crn;
  hbs_pkg::map_addr_t ram_addr;
  hbs_pkg::height_t   rdata;

  logic               rdv_q;
  hbs_pkg::corner_e   rdc_q;
  hbs_pkg::prod_t     prod;
  hbs_pkg::prod_t     acc_q;
  hbs_pkg::prod_t     top_q;
  hbs_pkg::prod_t     bot_q;
  hbs_pkg::sum_t      mtop_q;
  hbs_pkg::frac_t     fzb_q;
  hbs_pkg::shift_t    csb_q;
  logic               bv_q;
  hbs_pkg::sum_t      sum_q;
  hbs_pkg::s2_t       s2_q;
  logic               ov_q;

  // Sequencer: one memory access per cycle
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    ram_we   = 1'b0;
    rd_en    = 1'b0;
    rd_crn   = hbs_pkg::CRN_00;
    ram_addr = head_i.cmd.waddr;
    unique case (state_q)
      hbs_pkg::SEQ_IDLE: begin
        if (head_i.vld) begin
          pop_o = 1'b1;
          if (head_i.cmd.func == hbs_pkg::FUNC_WRITE) begin
            ram_we = 1'b1;
          end else begin
            rd_en    = 1'b1;
            load     = 1'b1;
            ram_addr = {head_i.cmd.row0, head_i.cmd.col0};
            state_d  = hbs_pkg::SEQ_C01;
          end
        end
      end
      hbs_pkg::SEQ_C01: begin
        rd_en    = 1'b1;
        rd_crn   = hbs_pkg::CRN_01;
        ram_addr = {cur_q.row0, cur_q.col1};
        state_d  = hbs_pkg::SEQ_C10;
      end
      hbs_pkg::SEQ_C10: begin
        rd_en    = 1'b1;
        rd_crn   = hbs_pkg::CRN_10;
        ram_addr = {cur_q.row1, cur_q.col0};
        state_d  = hbs_pkg::SEQ_C11;
      end
      hbs_pkg::SEQ_C11: begin
        rd_en    = 1'b1;
        rd_crn   = hbs_pkg::CRN_11;
        ram_addr = {cur_q.row1, cur_q.col1};
        state_d  = hbs_pkg::SEQ_IDLE;
      end
      default: begin
        state_d = hbs_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbs_pkg::SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Query context; used while its corner data comes back
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= head_i.cmd;
    end
  end

  hbs_ram #(
    .WIDTH (hbs_pkg::HEIGHT_W),
    .DEPTH (hbs_pkg::MAP_DEPTH)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (head_i.cmd.wdata),
    .rdata_o (rdata)
  );

  // Left corners take weight 1-fx, right corners fx
  always_comb begin
    if (rdc_q == hbs_pkg::CRN_00 || rdc_q == hbs_pkg::CRN_10) begin
      prod = hbs_pkg::prod_t'(rdata) * hbs_pkg::prod_t'(cur_q.wx);
    end else begin
      prod = hbs_pkg::prod_t'(rdata) * hbs_pkg::prod_t'(cur_q.fx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      bv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      rdv_q <= rd_en;
      bv_q  <= rdv_q && (rdc_q == hbs_pkg::CRN_11);
      ov_q  <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdc_q <= rd_crn;
    if (rdv_q) begin
      unique case (rdc_q)
        hbs_pkg::CRN_00: begin
          acc_q <= prod;
        end
        hbs_pkg::CRN_01: begin
          top_q <= acc_q + prod;
        end
        hbs_pkg::CRN_10: begin
          acc_q  <= prod;
          mtop_q <= hbs_pkg::sum_t'(top_q) * hbs_pkg::sum_t'(cur_q.wz);
        end
        hbs_pkg::CRN_11: begin
          bot_q <= acc_q + prod;
          fzb_q <= cur_q.fz;
          csb_q <= cur_q.cs;
        end
        default: begin
          acc_q <= prod;
        end
      endcase
    end
    if (bv_q) begin
      sum_q <= mtop_q + hbs_pkg::sum_t'(bot_q) * hbs_pkg::sum_t'(fzb_q);
      s2_q  <= hbs_pkg::s2_t'({hbs_pkg::fsh_t'(hbs_pkg::POS_FRAC_BITS)
                               + hbs_pkg::fsh_t'(csb_q), 1'b0});
    end
  end

  // Final scale straight off the sum register, in step with the strobe
  assign result_valid_o  = ov_q;
  assign ground_height_o = hbs_pkg::gh_t'((hbs_pkg::wide_t'(sum_q) << 8) >> s2_q);

endmodule

`default_nettype wire

// ===== rtl/core/heightmap_bilinear_sampler.sv =====
// ---------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Byte heightmap with bilinear height lookup at fixed-point positions.
// ---------------------------------------------------------------------------
// Usage:
//  - Command beat: start_i high while busy_o low. func_i = 0 writes
//    map_value_i at map_addr_i (row * 1024 + column); func_i = 1 queries
//    the height at (pos_x_i, pos_z_i), unsigned with 8 fraction bits.
//  - Config: cfg_we_i loads cell_shift (log2 of cell width) from
//    cfg_wdata_i; write it only while the block is idle.
//  - Result: one beat per query, result_valid_o high for one cycle with
//    ground_height_o (Q8.8, truncated). Writes give no result.
//  - Timing: a query reads its four corners from the single-port height
//    RAM, one corner read per cycle (C00, C01, C10, C11); a write uses the
//    port once. Writes go one per cycle while no query holds the port; the
//    next query's reads may begin while the last result is being blended.
//  - A 4-entry queue sits between the front end and the RAM sequencer;
//    busy_o is high only while that queue is full.
//  - The receiver cannot stall; results are strobed and never held.
//  - Reset empties the queue, stops the sequencer and sets cell_shift to 4.
//    Map contents are not cleared: read only entries already written.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module heightmap_bilinear_sampler (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   func_i,
  input  hbs_pkg::map_addr_t     map_addr_i,
  input  hbs_pkg::height_t       map_value_i,
  input  hbs_pkg::pos_t          pos_x_i,
  input  hbs_pkg::pos_t          pos_z_i,
  input  logic                   cfg_we_i,
  input  hbs_pkg::shift_t        cfg_wdata_i,
  output logic                   result_valid_o,
  output hbs_pkg::gh_t           ground_height_o
);

  hbs_pkg::shift_t cell_shift_q;
  logic            push;
  logic            q_full;
  logic            q_pop;
  hbs_pkg::cmd_t   push_cmd;
  hbs_pkg::qhead_t q_head;

  // cell_shift config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_shift_q <= hbs_pkg::CELL_SHIFT_RST;
    end else if (cfg_we_i) begin
      cell_shift_q <= cfg_wdata_i;
    end
  end

  // Front end: accept and classify, corner indices and weights up front
  hbs_front u_front (
    .start_i      (start_i),
    .full_i       (q_full),
    .func_i       (func_i),
    .map_addr_i   (map_addr_i),
    .map_value_i  (map_value_i),
    .pos_x_i      (pos_x_i),
    .pos_z_i      (pos_z_i),
    .cell_shift_i (cell_shift_q),
    .busy_o       (busy_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  hbs_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (q_pop),
    .full_o (q_full),
    .head_o (q_head)
  );

  // Back end: RAM sequencer plus blend pipeline
  hbs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .result_valid_o  (result_valid_o),
    .ground_height_o (ground_height_o)
  );

  // A query's four corner reads hold the RAM, so result beats never touch
  `HBS_ASSERT(a_result_gap, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "back-to-back results")
  // Sequencer must never take from an empty queue
  `HBS_ASSERT(a_pop_nonempty, clk_i, rst_ni, q_pop |-> q_head.vld, "pop from empty queue")
  // A push without a pop leaves something queued
  `HBS_ASSERT(a_push_lands, clk_i, rst_ni, (push && !q_pop) |=> q_head.vld, "pushed beat lost")
  // No result strobe while in reset
  `HBS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !result_valid_o, "result during reset")

endmodule

`default_nettype wire
